[hw/rtl/zobrist_board_hash_core_defines.svh]
// Assertion macros shared by the Zobrist hash core.
`ifndef ZOBRIST_BOARD_HASH_CORE_DEFINES_SVH
`define ZOBRIST_BOARD_HASH_CORE_DEFINES_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define ZBH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zbh: same-cycle check failed");

// ante holds in a cycle -> cons holds from the next cycle on (cons may carry ##n)
`define ZBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("zbh: next-cycle check failed");

`endif

[hw/rtl/zbh_pkg.sv]
// Package: key table generator, types and constants of the Zobrist hash core.
package zbh_pkg;

    localparam int unsigned SQUARE_COUNT_DEF = 32;
    localparam int unsigned PIECE_KINDS      = 4;
    localparam int unsigned MASK_W           = 32;
    localparam int unsigned KEY_W            = 64;
    localparam int unsigned GROUP_SIZE       = 8;

    localparam logic [KEY_W-1:0] KEY_SEED  = 64'hDA3A_5C05_1A11_A415;
    localparam logic [KEY_W-1:0] KEY_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [KEY_W-1:0] KEY_MUL1  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [KEY_W-1:0] KEY_MUL2  = 64'h94D0_49BB_1331_11EB;

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [MASK_W-1:0] t_mask;

    typedef struct packed {
        logic grp;
        logic kind;
    } t_stage_en;

    // SplitMix64 output n; evaluated at elaboration only
    function automatic t_key key_at(input int unsigned n);
        t_key z;
        z = KEY_SEED + KEY_W'(n + 1) * KEY_GAMMA;
        z = (z ^ (z >> 30)) * KEY_MUL1;
        z = (z ^ (z >> 27)) * KEY_MUL2;
        return z ^ (z >> 31);
    endfunction

endpackage

[hw/rtl/zbh_kind_hash.sv]
// One piece kind: masked key selection, group fold, kind fold over two stages.
module zbh_kind_hash #(
    parameter int unsigned SQUARE_COUNT = zbh_pkg::SQUARE_COUNT_DEF,
    parameter int unsigned KIND         = 0
) (
    input  logic              i_clk,
    input  zbh_pkg::t_mask    i_mask,
    input  zbh_pkg::t_stage_en i_en,
    output zbh_pkg::t_key     o_hash
);
    import zbh_pkg::*;

    localparam int unsigned GROUPS = (SQUARE_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;

    t_key w_term [GROUPS][GROUP_SIZE];
    t_key n_grp  [GROUPS];
    t_key r_grp  [GROUPS];
    t_key n_hash;
    t_key r_hash;

    for (genvar g = 0; g < GROUPS; g++) begin : g_grp
        for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_sq
            if (g * GROUP_SIZE + j < SQUARE_COUNT) begin : g_on
                localparam t_key KEY = key_at(KIND * SQUARE_COUNT + g * GROUP_SIZE + j);
                assign w_term[g][j] = i_mask[g * GROUP_SIZE + j] ? KEY : '0;
            end else begin : g_off
                assign w_term[g][j] = '0;
            end
        end
    end

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                n_grp[g] = n_grp[g] ^ w_term[g][j];
            end
        end
    end

    always_comb begin
        n_hash = '0;
        for (int g = 0; g < GROUPS; g++) begin
            n_hash = n_hash ^ r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.grp) begin
            r_grp <= n_grp;
        end
        if (i_en.kind) begin
            r_hash <= n_hash;
        end
    end

    assign o_hash = r_hash;

endmodule

[hw/rtl/zobrist_board_hash_core.sv]
// Top level: pipelined Zobrist position hash for a 32-square draughts board.
//
// Usage:
//   Drive the four occupancy masks and i_black_to_move and raise start for
//   one cycle per position. busy is always low, so a word is taken at every
//   edge with start high; positions may follow each other every cycle.
//   o_position_hash is shown for one cycle with o_strobe high, in the order
//   the words came in.
//   Pipeline: input register, per-kind group fold (eight squares each),
//   per-kind fold, final XOR with the player key into the output register.
//   Throughput one word per cycle; each word passes through those four
//   register stages in order.
//   Reset (i_rst_n low, synchronous) drops every word in flight; no strobe
//   follows for words taken before it.
//   The receiver cannot stall; results are never held or repeated.
module zobrist_board_hash_core #(
    parameter int unsigned SQUARE_COUNT = zbh_pkg::SQUARE_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  zbh_pkg::t_mask i_white_men_mask,
    input  zbh_pkg::t_mask i_white_kings_mask,
    input  zbh_pkg::t_mask i_black_men_mask,
    input  zbh_pkg::t_mask i_black_kings_mask,
    input  logic           i_black_to_move,
    output logic           o_strobe,
    output zbh_pkg::t_key  o_position_hash
);
    import zbh_pkg::*;

    `include "zobrist_board_hash_core_defines.svh"

    localparam t_key PLAYER_KEY = key_at(PIECE_KINDS * SQUARE_COUNT);

    logic  r_vld_s1, r_vld_s2, r_vld_s3, r_strobe;
    logic  r_btm_s1, r_btm_s2, r_btm_s3;
    t_mask r_mask_s1 [PIECE_KINDS];
    t_key  w_kind    [PIECE_KINDS];
    t_key  n_hash;
    t_key  r_hash;
    t_stage_en w_en;

    assign busy = 1'b0;
    assign w_en = '{grp: r_vld_s1, kind: r_vld_s2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_s1 <= 1'b0;
            r_vld_s2 <= 1'b0;
            r_vld_s3 <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_vld_s1 <= start && !busy;
            r_vld_s2 <= r_vld_s1;
            r_vld_s3 <= r_vld_s2;
            r_strobe <= r_vld_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_mask_s1[0] <= i_white_men_mask;
            r_mask_s1[1] <= i_white_kings_mask;
            r_mask_s1[2] <= i_black_men_mask;
            r_mask_s1[3] <= i_black_kings_mask;
            r_btm_s1     <= i_black_to_move;
        end
        if (r_vld_s1) begin
            r_btm_s2 <= r_btm_s1;
        end
        if (r_vld_s2) begin
            r_btm_s3 <= r_btm_s2;
        end
        if (r_vld_s3) begin
            r_hash <= n_hash;
        end
    end

    for (genvar k = 0; k < PIECE_KINDS; k++) begin : g_kind
        zbh_kind_hash #(
            .SQUARE_COUNT (SQUARE_COUNT),
            .KIND         (k)
        ) u_kind (
            .i_clk  (i_clk),
            .i_mask (r_mask_s1[k]),
            .i_en   (w_en),
            .o_hash (w_kind[k])
        );
    end

    always_comb begin
        n_hash = r_btm_s3 ? PLAYER_KEY : '0;
        for (int k = 0; k < PIECE_KINDS; k++) begin
            n_hash = n_hash ^ w_kind[k];
        end
    end

    assign o_strobe        = r_strobe;
    assign o_position_hash = r_hash;

    `ZBH_ASSERT_NEXT(a_word_reaches_out, i_clk, i_rst_n, start && !busy, ##3 o_strobe)
    `ZBH_ASSERT_NEXT(a_empty_board_zero, i_clk, i_rst_n,
        r_vld_s1 && !r_btm_s1 && r_mask_s1[0] == '0 && r_mask_s1[1] == '0
        && r_mask_s1[2] == '0 && r_mask_s1[3] == '0, ##2 (o_position_hash == '0))
    `ZBH_ASSERT_NOW(a_strobe_has_source, i_clk, i_rst_n, o_strobe, $past(r_vld_s3))

endmodule

[test/tb_zobrist_board_hash_core.sv]
// Testbench for zobrist_board_hash_core: positions checked against a key-table predictor.
module tb_zobrist_board_hash_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD     = 10;
    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned BOARD_KEYS     = zbh_pkg::PIECE_KINDS * zbh_pkg::SQUARE_COUNT_DEF;
    localparam int unsigned PLAYER_KEY_IDX = BOARD_KEYS;
    localparam int unsigned PHASE_WORDS    = 600;
    localparam int unsigned DRAIN_CYCLES   = 16;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned PRINT_LIMIT    = 20;

    class hash_scoreboard;
        zbh_pkg::t_key square_keys[BOARD_KEYS + 1];
        zbh_pkg::t_key expected_hashes[$];
        int unsigned   mismatch_count;

        // keys from the running generator: advance by gamma, then mix
        function new();
            zbh_pkg::t_key gen_state;
            zbh_pkg::t_key z;
            gen_state = zbh_pkg::KEY_SEED;
            for (int n = 0; n <= BOARD_KEYS; n++) begin
                gen_state = gen_state + zbh_pkg::KEY_GAMMA;
                z = gen_state;
                z = (z ^ (z >> 30)) * zbh_pkg::KEY_MUL1;
                z = (z ^ (z >> 27)) * zbh_pkg::KEY_MUL2;
                square_keys[n] = z ^ (z >> 31);
            end
            mismatch_count = 0;
        endfunction

        function void report_mismatch(string what);
            mismatch_count++;
            if (mismatch_count <= PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $time, what);
        endfunction

        function void note_position(zbh_pkg::t_mask wm, zbh_pkg::t_mask wk,
                                    zbh_pkg::t_mask bm, zbh_pkg::t_mask bk, logic btm);
            zbh_pkg::t_mask occupancy[zbh_pkg::PIECE_KINDS];
            zbh_pkg::t_key  h;
            occupancy[0] = wm;
            occupancy[1] = wk;
            occupancy[2] = bm;
            occupancy[3] = bk;
            h = '0;
            for (int k = 0; k < zbh_pkg::PIECE_KINDS; k++)
                for (int sq = 0; sq < zbh_pkg::SQUARE_COUNT_DEF; sq++)
                    if (occupancy[k][sq])
                        h ^= square_keys[k * zbh_pkg::SQUARE_COUNT_DEF + sq];
            if (btm)
                h ^= square_keys[PLAYER_KEY_IDX];
            expected_hashes.push_back(h);
        endfunction

        function void check_hash(zbh_pkg::t_key got);
            zbh_pkg::t_key want;
            if (expected_hashes.size() == 0) begin
                report_mismatch($sformatf("hash %h with no position pending", got));
                return;
            end
            want = expected_hashes.pop_front();
            if (got !== want)
                report_mismatch($sformatf("position_hash %h, expected %h", got, want));
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    zbh_pkg::t_mask i_white_men_mask = '0;
    zbh_pkg::t_mask i_white_kings_mask = '0;
    zbh_pkg::t_mask i_black_men_mask = '0;
    zbh_pkg::t_mask i_black_kings_mask = '0;
    logic           i_black_to_move = 1'b0;
    logic           o_strobe;
    zbh_pkg::t_key  o_position_hash;

    hash_scoreboard hash_sb;
    int unsigned    sender_idle_pct = 0;
    int unsigned    cycle_count = 0;

    zobrist_board_hash_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_white_men_mask   (i_white_men_mask),
        .i_white_kings_mask (i_white_kings_mask),
        .i_black_men_mask   (i_black_men_mask),
        .i_black_kings_mask (i_black_kings_mask),
        .i_black_to_move    (i_black_to_move),
        .o_strobe           (o_strobe),
        .o_position_hash    (o_position_hash)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // words taken and hashes returned, both sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                hash_sb.note_position(i_white_men_mask, i_white_kings_mask,
                                      i_black_men_mask, i_black_kings_mask, i_black_to_move);
            if (o_strobe === 1'b1)
                hash_sb.check_hash(o_position_hash);
            else if (o_strobe !== 1'b0)
                hash_sb.report_mismatch("strobe unknown");
        end
    end

    function automatic zbh_pkg::t_mask rand_mask();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        if (pick <= 4)
            return $urandom & $urandom & $urandom;
        if (pick <= 6)
            return $urandom | $urandom;
        return $urandom;
    endfunction

    task automatic send_position(input zbh_pkg::t_mask wm, input zbh_pkg::t_mask wk,
                                 input zbh_pkg::t_mask bm, input zbh_pkg::t_mask bk,
                                 input logic btm);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start              <= 1'b1;
        i_white_men_mask   <= wm;
        i_white_kings_mask <= wk;
        i_black_men_mask   <= bm;
        i_black_kings_mask <= bk;
        i_black_to_move    <= btm;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (hash_sb.expected_hashes.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        zbh_pkg::t_mask sel[zbh_pkg::PIECE_KINDS];
        int unsigned    phase_pct[3];
        hash_sb = new();
        phase_pct[0] = 22;
        phase_pct[1] = 69;
        phase_pct[2] = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty board, full boards, overlaps, alternating squares
        send_position('0, '0, '0, '0, 1'b0);
        send_position('0, '0, '0, '0, 1'b1);
        send_position('1, '0, '0, '0, 1'b0);
        send_position('0, '1, '0, '0, 1'b1);
        send_position('0, '0, '1, '0, 1'b0);
        send_position('0, '0, '0, '1, 1'b1);
        send_position('1, '1, '1, '1, 1'b0);
        send_position('1, '1, '1, '1, 1'b1);
        send_position(32'h0F0F_0F0F, 32'h0F0F_0F0F, 32'h0F0F_0F0F, 32'h0F0F_0F0F, 1'b1);
        send_position(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        // lowest and highest square of each kind alone
        for (int k = 0; k < zbh_pkg::PIECE_KINDS; k++) begin
            for (int b = 0; b < 2; b++) begin
                foreach (sel[j])
                    sel[j] = '0;
                sel[k] = (b == 0) ? 32'h0000_0001 : 32'h8000_0000;
                send_position(sel[0], sel[1], sel[2], sel[3], 1'(b));
            end
        end
        wait_drained();

        // sender idles now and then, then often, then never; full drain between phases
        for (int p = 0; p < 3; p++) begin
            sender_idle_pct = phase_pct[p];
            repeat (PHASE_WORDS)
                send_position(rand_mask(), rand_mask(), rand_mask(), rand_mask(),
                              1'($urandom_range(1)));
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (hash_sb.expected_hashes.size() != 0)
            hash_sb.report_mismatch($sformatf("hash %h never returned",
                                              hash_sb.expected_hashes.pop_front()));
        if (hash_sb.mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
